@@ rtl/core/sdtl_pkg.sv @@
package sdtl_pkg;

	// Operation codes on the input channel
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	localparam int DEF_NUM_TIMERS = 16;
	localparam int MAX_RESULTS    = 16;
	localparam int CNT_W          = 5;
	localparam int SLOT_EXT_W     = 6;
	localparam int MASK_W         = 16;

	// Register indexes on the configuration port
	localparam logic REG_PERIODIC = 1'b0;
	localparam logic REG_NOTIFY   = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic latch_in;
		logic tick_inc;
		logic remove;
		logic st_write;
		logic ins_adv;
		logic ins_put;
		logic rd_head;
		logic fire;
		logic push_mid;
		logic load_pend;
		logic push_end;
	} sdtl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic slot_ok;
		logic ins_full;
		logic ins_end;
		logic ins_less;
		logic head_empty;
		logic head_fired;
		logic head_early;
		logic emit;
		logic periodic;
		logic pend_valid;
		logic out_free;
	} sdtl_sts_t;

	// Masks cover slots 0 to 15 only
	function automatic logic mask_bit(input logic [MASK_W-1:0] m,
			input logic [SLOT_EXT_W-1:0] s);
		return (s < SLOT_EXT_W'(MASK_W)) && m[s[3:0]];
	endfunction

endpackage

@@ rtl/core/sdtl_ctrl.sv @@
module sdtl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         operation,
	output logic               in_stall,
	input  sdtl_pkg::sdtl_sts_t sts,
	output sdtl_pkg::sdtl_cmd_t cmd
);
	import sdtl_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_REMOVE, ST_WRITE, ST_INS_RD, ST_INS_CMP, ST_INS_PUT,
		ST_T_HEAD, ST_T_CHK, ST_T_NOTE, ST_T_END
	} state_t;

	state_t state_q, state_d;
	logic   tick_ctx_q, tick_ctx_d;
	logic   start_q, start_d;
	state_t ret_st;

	assign in_stall = (state_q != ST_IDLE);
	assign ret_st   = tick_ctx_q ? ST_T_HEAD : ST_IDLE;

	// Decode state into commands and next state
	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		tick_ctx_d = tick_ctx_q;
		start_d    = start_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					case (operation)
						OP_TICK: begin
							cmd.tick_inc = 1'b1;
							tick_ctx_d   = 1'b1;
							state_d      = ST_T_HEAD;
						end
						OP_START: begin
							tick_ctx_d = 1'b0;
							start_d    = 1'b1;
							if (sts.slot_ok) state_d = ST_REMOVE;
						end
						OP_STOP: begin
							tick_ctx_d = 1'b0;
							start_d    = 1'b0;
							if (sts.slot_ok) state_d = ST_REMOVE;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_REMOVE: begin
				cmd.remove = 1'b1;
				state_d    = start_q ? ST_WRITE : ret_st;
			end
			ST_WRITE: begin
				cmd.st_write = 1'b1;
				state_d      = ST_INS_RD;
			end
			ST_INS_RD: begin
				if (sts.ins_full) state_d = ret_st;
				else if (sts.ins_end) state_d = ST_INS_PUT;
				else state_d = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				if (sts.ins_less) state_d = ST_INS_PUT;
				else begin
					cmd.ins_adv = 1'b1;
					state_d     = ST_INS_RD;
				end
			end
			ST_INS_PUT: begin
				cmd.ins_put = 1'b1;
				state_d     = ret_st;
			end
			ST_T_HEAD: begin
				cmd.rd_head = 1'b1;
				if (sts.head_empty || sts.head_fired) state_d = ST_T_END;
				else state_d = ST_T_CHK;
			end
			ST_T_CHK: begin
				if (sts.head_early) state_d = ST_T_END;
				else begin
					cmd.fire = 1'b1;
					state_d  = ST_T_NOTE;
				end
			end
			ST_T_NOTE: begin
				if (!(sts.emit && sts.pend_valid && !sts.out_free)) begin
					cmd.push_mid  = sts.emit;
					cmd.load_pend = sts.emit;
					start_d       = sts.periodic;
					state_d       = ST_REMOVE;
				end
			end
			ST_T_END: begin
				if (!sts.pend_valid) state_d = ST_IDLE;
				else if (sts.out_free) begin
					cmd.push_end = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tick_ctx_q <= 1'b0;
			start_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			tick_ctx_q <= tick_ctx_d;
			start_q    <= start_d;
		end
	end

endmodule

@@ rtl/core/sdtl_dp.sv @@
module sdtl_dp #(
	parameter int NUM_TIMERS = sdtl_pkg::DEF_NUM_TIMERS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          slot_index,
	input  logic [31:0]         duration,
	input  logic [15:0]         periodic_mask,
	input  logic [15:0]         notify_mask,
	input  sdtl_pkg::sdtl_cmd_t cmd,
	output sdtl_pkg::sdtl_sts_t sts,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [3:0]          fired_slot,
	output logic                last_fire
);
	import sdtl_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int LW = $clog2(NUM_TIMERS + 1);

	logic [31:0]          now_q;
	logic                 cur_q;
	logic [LW-1:0]        len_q [2];
	logic [IW-1:0]        ord_q [2][NUM_TIMERS];
	logic [IW-1:0]        slot_q;
	logic [31:0]          dur_q;
	logic [31:0]          dl_new_q;
	logic                 ins_p_q;
	logic [LW-1:0]        pos_q;
	logic [NUM_TIMERS-1:0] fired_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 pend_valid_q;
	logic [IW-1:0]        pend_slot_q;
	logic                 out_valid_q;
	logic [3:0]           out_slot_q;
	logic                 out_last_q;
	logic [63:0]          mem [NUM_TIMERS];
	logic [63:0]          rd_q;

	logic [IW-1:0] head;
	logic [IW-1:0] rd_addr;
	logic [32:0]   sum;
	logic          out_free;
	logic          push;
	logic [31:0]   now_inc;

	assign head     = ord_q[cur_q][0];
	assign rd_addr  = cmd.rd_head ? head : ord_q[ins_p_q][pos_q[IW-1:0]];
	assign sum      = {1'b0, now_q} + {1'b0, dur_q};
	assign out_free = !out_valid_q || !out_stall;
	assign push     = (cmd.push_mid && pend_valid_q) || cmd.push_end;
	assign now_inc  = now_q + 32'd1;

	// Report status
	always_comb begin
		sts.slot_ok    = {3'b0, slot_index} < 7'(NUM_TIMERS);
		sts.ins_full   = len_q[ins_p_q] >= LW'(NUM_TIMERS);
		sts.ins_end    = pos_q == len_q[ins_p_q];
		sts.ins_less   = dl_new_q < rd_q[31:0];
		sts.head_empty = len_q[cur_q] == '0;
		sts.head_fired = fired_q[head];
		sts.head_early = now_q < rd_q[31:0];
		sts.emit       = mask_bit(notify_mask, SLOT_EXT_W'(slot_q)) &&
			(cnt_q < CNT_W'(MAX_RESULTS));
		sts.periodic   = mask_bit(periodic_mask, SLOT_EXT_W'(slot_q));
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
	end

	// Deadline and period store, registered read
	always_ff @(posedge clk) begin
		if (cmd.st_write) mem[slot_q] <= {dur_q, sum[31:0]};
		rd_q <= mem[rd_addr];
	end

	// Latch operands, track insertion and scan
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			slot_q <= IW'(slot_index);
			dur_q  <= duration;
		end
		if (cmd.fire) begin
			slot_q <= head;
			dur_q  <= rd_q[63:32];
		end
		if (cmd.st_write) begin
			dl_new_q <= sum[31:0];
			ins_p_q  <= cur_q ^ sum[32];
			pos_q    <= '0;
		end
		if (cmd.ins_adv) pos_q <= pos_q + LW'(1);
		if (cmd.load_pend) pend_slot_q <= slot_q;
	end

	// Time, lists and per-tick bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			cur_q        <= 1'b0;
			len_q[0]     <= '0;
			len_q[1]     <= '0;
			fired_q      <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.tick_inc) begin
				now_q   <= now_inc;
				if (now_inc == '0) cur_q <= ~cur_q;
				fired_q <= '0;
				cnt_q   <= '0;
			end
			if (cmd.fire) fired_q[head] <= 1'b1;
			if (cmd.remove) begin
				for (int p = 0; p < 2; p++) begin
					if (len_q[p] != '0) begin
						for (int k = 0; k < NUM_TIMERS; k++) begin
							if (LW'(k) < len_q[p] && ord_q[p][k] == slot_q) begin
								len_q[p] <= len_q[p] - LW'(1);
							end
						end
					end
				end
			end
			if (cmd.ins_put) len_q[ins_p_q] <= len_q[ins_p_q] + LW'(1);
			if (cmd.load_pend) begin
				pend_valid_q <= 1'b1;
				cnt_q        <= cnt_q + CNT_W'(1);
			end
			if (cmd.push_end) pend_valid_q <= 1'b0;
		end
	end

	// Shift list order on removal and insertion
	always_ff @(posedge clk) begin
		logic ge;
		for (int p = 0; p < 2; p++) begin
			ge = 1'b0;
			for (int k = 0; k < NUM_TIMERS; k++) begin
				ge = ge || (LW'(k) < len_q[p] && ord_q[p][k] == slot_q);
				if (cmd.remove && ge && k < NUM_TIMERS - 1) begin
					ord_q[p][k] <= ord_q[p][k+1];
				end
				if (cmd.ins_put && ins_p_q == p[0]) begin
					if (LW'(k) == pos_q) ord_q[p][k] <= slot_q;
					else if (LW'(k) > pos_q && k > 0) ord_q[p][k] <= ord_q[p][k-1];
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_slot_q  <= '0;
			out_last_q  <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
			out_slot_q  <= 4'(pend_slot_q);
			out_last_q  <= cmd.push_end;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign fired_slot = out_slot_q;
	assign last_fire  = out_last_q;

`ifndef SYNTHESIS
	a_len_total: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, len_q[0]} + {1'b0, len_q[1]}) <= (LW+1)'(NUM_TIMERS))
		else $error("lists hold more entries than slots");
	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_put |-> len_q[ins_p_q] < LW'(NUM_TIMERS))
		else $error("insert into full list");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("fire results exceed cap");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("output overwritten while stalled");
`endif

endmodule

@@ rtl/core/sorted_deadline_timer_list.sv @@
// Sorted deadline timer list: NUM_TIMERS slots kept in two deadline-sorted
// lists (current and overflow) under a 32-bit tick counter. One item is in
// work at a time. A start walks the target list in sorted order, reading one
// deadline per step from the single-port slot store. A tick reads the head
// and stops when the list is empty or the head has already fired or is not
// yet due; each slot that fires is then removed or, if periodic, restarted.
// Fire results are queued one deep behind the output register, so a stalled
// output holds the block when a notify finds both full, and at the end of a
// tick while a queued beat waits.
// Configuration registers: periodic_mask at 0x0, notify_mask at 0x4.
module sorted_deadline_timer_list #(
	parameter int NUM_TIMERS = sdtl_pkg::DEF_NUM_TIMERS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [3:0]  slot_index,
	input  logic [31:0] duration,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  fired_slot,
	output logic        last_fire
);
	import sdtl_pkg::*;

	logic [MASK_W-1:0] periodic_mask_q;
	logic [MASK_W-1:0] notify_mask_q;
	sdtl_cmd_t         cmd;
	sdtl_sts_t         sts;

	assign pready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periodic_mask_q <= '0;
			notify_mask_q   <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_PERIODIC: periodic_mask_q <= pwdata[MASK_W-1:0];
				REG_NOTIFY:   notify_mask_q   <= pwdata[MASK_W-1:0];
				default:      periodic_mask_q <= periodic_mask_q;
			endcase
		end
	end

	// Configuration reads
	always_comb begin
		case (paddr[2])
			REG_PERIODIC: prdata = {16'b0, periodic_mask_q};
			REG_NOTIFY:   prdata = {16'b0, notify_mask_q};
			default:      prdata = '0;
		endcase
	end

	sdtl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sdtl_dp #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.slot_index    (slot_index),
		.duration      (duration),
		.periodic_mask (periodic_mask_q),
		.notify_mask   (notify_mask_q),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fired_slot    (fired_slot),
		.last_fire     (last_fire)
	);

endmodule
